// File: sv/rrar_pkg.sv
// Shared types and codes for the request/response ACK/retry controller.
// Holds phase, event, transmit, timer, delivery, finish and config index codes plus the config and result structs.
// No dependencies.
`default_nettype none

package rrar_pkg;

    localparam int unsigned CountWidth = 8;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned InDataWidth = 8;
    localparam int unsigned InUserWidth = 3;
    localparam int unsigned OutDataWidth = 24;

    localparam logic [CountWidth-1:0] RetryMaxReset = 8'd3;
    localparam logic [CountWidth-1:0] RetrySat = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_REQ_SENT    = 3'd1,
        PH_ACK_RECV    = 3'd2,
        PH_RESP_RECV   = 3'd3,
        PH_APP_PROCESS = 3'd4,
        PH_RESP_SENT   = 3'd5,
        PH_FINALIZED   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        EV_SEND_REQ     = 3'd0,
        EV_RECV_REQ     = 3'd1,
        EV_RECV_ACK     = 3'd2,
        EV_RECV_RESP    = 3'd3,
        EV_RECV_ERROR   = 3'd4,
        EV_ACK_TIMEOUT  = 3'd5,
        EV_RESP_TIMEOUT = 3'd6,
        EV_APP_DONE     = 3'd7
    } event_t;

    typedef enum logic [2:0] {
        TX_NONE       = 3'd0,
        TX_REQUEST    = 3'd1,
        TX_RETRANSMIT = 3'd2,
        TX_ACK        = 3'd3,
        TX_ERR_PROC   = 3'd4,
        TX_ERR_NOTOK  = 3'd5,
        TX_RESPONSE   = 3'd6
    } tx_kind_t;

    typedef enum logic [1:0] {
        TM_NONE      = 2'd0,
        TM_ACK_WAIT  = 2'd1,
        TM_RESP_WAIT = 2'd2,
        TM_CANCEL    = 2'd3
    } timer_act_t;

    typedef enum logic [1:0] {
        DLV_NONE    = 2'd0,
        DLV_MESSAGE = 2'd1,
        DLV_FAILURE = 2'd2
    } delivery_t;

    typedef enum logic [1:0] {
        FIN_NORMAL  = 2'd0,
        FIN_RETRIES = 2'd1,
        FIN_ERROR   = 2'd2
    } fin_code_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_ACK_MAX  = 2'd0,
        CFG_RESP_MAX = 2'd1,
        CFG_PROC     = 2'd2,
        CFG_UNUSED   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CountWidth-1:0] ack_max;
        logic [CountWidth-1:0] resp_max;
        logic                  proc_flag;
    } cfg_t;

    typedef struct packed {
        logic                  unexpected;
        fin_code_t             finish_code;
        logic                  finalized;
        delivery_t             app_delivery;
        logic [CountWidth-1:0] retry_count_out;
        timer_act_t            timer_action;
        tx_kind_t              transmit_kind;
        phase_t                new_phase;
    } result_t;

endpackage

`default_nettype wire

// File: sv/rrar_cfg_regs.sv
// Configuration registers of the request/response controller.
// Depends on rrar_pkg for register indexes and the cfg_t struct.
`default_nettype none

module rrar_cfg_regs
    import rrar_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    input  wire logic [CfgIdxWidth-1:0] cfg_index,
    input  wire logic [CountWidth-1:0]  cfg_data,
    output cfg_t                        cfg
);

    logic [CountWidth-1:0] ack_max_reg;
    logic [CountWidth-1:0] resp_max_reg;
    logic                  proc_flag_reg;
    cfg_idx_t              idx;

    assign idx = cfg_idx_t'(cfg_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_max_reg   <= RetryMaxReset;
            resp_max_reg  <= RetryMaxReset;
            proc_flag_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (idx)
                CFG_ACK_MAX:  ack_max_reg   <= cfg_data;
                CFG_RESP_MAX: resp_max_reg  <= cfg_data;
                CFG_PROC:     proc_flag_reg <= cfg_data[0];
                default: begin
                    // no register at this index: drop the write
                end
            endcase
        end
    end

    assign cfg.ack_max   = ack_max_reg;
    assign cfg.resp_max  = resp_max_reg;
    assign cfg.proc_flag = proc_flag_reg;

endmodule

`default_nettype wire

// File: sv/rrar_step.sv
// Next-state and result logic for one protocol event.
// Purely combinational; depends on rrar_pkg for codes and structs.
`default_nettype none

module rrar_step
    import rrar_pkg::*;
(
    input  wire phase_t                 phase,
    input  wire logic [CountWidth-1:0]  retry_count,
    input  wire cfg_t                   cfg,
    input  wire logic [2:0]             command,
    input  wire logic                   error_is_processing,
    input  wire logic                   reply_valid,
    output phase_t                      phase_next,
    output logic [CountWidth-1:0]       retry_next,
    output result_t                     res
);

    event_t                ev;
    logic                  client;
    logic [CountWidth-1:0] retry_inc;
    logic [CountWidth-1:0] timeout_max;
    logic                  exceeded;
    tx_kind_t              tx;
    timer_act_t            tmr;
    delivery_t             dlv;
    logic                  fin;
    fin_code_t             code;
    logic                  unexp;

    assign client    = (phase == PH_REQ_SENT) || (phase == PH_ACK_RECV);
    assign retry_inc = (retry_count == RetrySat) ? retry_count : retry_count + 1'b1;
    assign timeout_max = (phase == PH_ACK_RECV) ? cfg.resp_max : cfg.ack_max;
    assign exceeded  = retry_inc > timeout_max;

    always_comb begin
        ev = event_t'(command);
        // a processing ERROR counts as an ACK in req_sent, ack_recv and resp_sent
        if (ev == EV_RECV_ERROR && error_is_processing &&
            (client || phase == PH_RESP_SENT)) begin
            ev = EV_RECV_ACK;
        end
    end

    always_comb begin
        phase_next = phase;
        retry_next = retry_count;
        tx    = TX_NONE;
        tmr   = TM_NONE;
        dlv   = DLV_NONE;
        fin   = 1'b0;
        code  = FIN_NORMAL;
        unexp = 1'b0;

        unique case (phase)
            PH_IDLE: begin
                if (ev == EV_SEND_REQ) begin
                    phase_next = PH_REQ_SENT;
                    tx  = TX_REQUEST;
                    tmr = TM_ACK_WAIT;
                end else if (ev == EV_RECV_REQ) begin
                    phase_next = PH_APP_PROCESS;
                    tx  = TX_ACK;
                    dlv = DLV_MESSAGE;
                end else begin
                    unexp = 1'b1;
                end
            end
            PH_REQ_SENT, PH_ACK_RECV, PH_RESP_SENT: begin
                if (ev == EV_RECV_RESP && client) begin
                    phase_next = PH_FINALIZED;
                    tx   = TX_ACK;
                    tmr  = TM_CANCEL;
                    dlv  = DLV_MESSAGE;
                    fin  = 1'b1;
                end else if (ev == EV_RECV_ERROR) begin
                    phase_next = PH_FINALIZED;
                    tx   = TX_ACK;
                    tmr  = TM_CANCEL;
                    dlv  = client ? DLV_MESSAGE : DLV_NONE;
                    fin  = 1'b1;
                    code = FIN_ERROR;
                end else if ((ev == EV_ACK_TIMEOUT && phase != PH_ACK_RECV) ||
                             (ev == EV_RESP_TIMEOUT && phase == PH_ACK_RECV)) begin
                    retry_next = retry_inc;
                    if (exceeded) begin
                        phase_next = PH_FINALIZED;
                        fin  = 1'b1;
                        code = FIN_RETRIES;
                        dlv  = client ? DLV_FAILURE : DLV_NONE;
                    end else begin
                        tx  = TX_RETRANSMIT;
                        tmr = (phase == PH_ACK_RECV) ? TM_RESP_WAIT : TM_ACK_WAIT;
                    end
                end else if (ev == EV_RECV_ACK && phase == PH_REQ_SENT) begin
                    phase_next = PH_ACK_RECV;
                    tmr = TM_RESP_WAIT;
                end else if (ev == EV_RECV_ACK && phase == PH_RESP_SENT) begin
                    phase_next = PH_FINALIZED;
                    tmr = TM_CANCEL;
                    fin = 1'b1;
                end else if ((ev == EV_RECV_ACK && phase == PH_ACK_RECV) ||
                             (ev == EV_RECV_REQ && phase == PH_RESP_SENT)) begin
                    // duplicate: hold everything, no action
                end else begin
                    unexp = 1'b1;
                end
            end
            PH_APP_PROCESS: begin
                if (ev == EV_APP_DONE) begin
                    phase_next = PH_RESP_SENT;
                    tx  = reply_valid ? TX_RESPONSE : TX_ERR_NOTOK;
                    tmr = TM_ACK_WAIT;
                end else if (ev == EV_RECV_REQ) begin
                    tx = cfg.proc_flag ? TX_ERR_PROC : TX_ACK;
                end else begin
                    unexp = 1'b1;
                end
            end
            default: begin
                // resp_recv, finalized and the unused code accept nothing
                unexp = 1'b1;
            end
        endcase
    end

    assign res.new_phase       = phase_next;
    assign res.transmit_kind   = tx;
    assign res.timer_action    = tmr;
    assign res.retry_count_out = retry_next;
    assign res.app_delivery    = dlv;
    assign res.finalized       = fin;
    assign res.finish_code     = code;
    assign res.unexpected      = unexp;

endmodule

`default_nettype wire

// File: sv/request_response_ack_retry_fsm.sv
// Top level of the stop-and-wait request/response controller.
// Uses rrar_pkg, rrar_cfg_regs and rrar_step.
//
//   channel   | direction | handshake              | payload
//   s_axis    | in        | s_axis_tvalid/tready   | tuser: command; tdata: event flags
//   m_axis    | out       | m_axis_tvalid/tready   | tdata: 22-bit result, zero padded
//   cfg       | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One event per cycle sustained while m_axis is not stalled; an accepted event waits
// in the input register, then its result from the step logic enters the result register
// and is shown on m_axis.
// The phase and retry count update when an event moves into the result register.
// Reset (aresetn low, synchronous) returns to idle with retry count zero and defaults.
// A stalled m_axis holds the result; one more event waits in the input register.
`default_nettype none

module request_response_ack_retry_fsm
    import rrar_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // [0] error_is_processing, [1] reply_valid, [7:2] zero
    input  wire logic [InDataWidth-1:0]  s_axis_tdata,
    // [2:0] command
    input  wire logic [InUserWidth-1:0]  s_axis_tuser,

    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // [2:0] new_phase, [5:3] transmit_kind, [7:6] timer_action,
    // [15:8] retry_count_out, [17:16] app_delivery, [18] finalized,
    // [20:19] finish_code, [21] unexpected, [23:22] zero
    output logic [OutDataWidth-1:0]      m_axis_tdata,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [CountWidth-1:0]   cfg_data
);

    localparam int unsigned ResWidth = $bits(result_t);

    cfg_t                  cfg;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [CountWidth-1:0] retry_reg;
    logic [CountWidth-1:0] retry_next;

    logic                  in_valid_reg;
    logic [2:0]            in_cmd_reg;
    logic                  in_proc_reg;
    logic                  in_reply_reg;

    logic                  out_valid_reg;
    result_t               out_res_reg;
    result_t               res;

    logic                  s_fire;
    logic                  out_free;
    logic                  step_fire;

    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step_fire     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    rrar_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rrar_step u_step (
        .phase               (phase_reg),
        .retry_count         (retry_reg),
        .cfg                 (cfg),
        .command             (in_cmd_reg),
        .error_is_processing (in_proc_reg),
        .reply_valid         (in_reply_reg),
        .phase_next          (phase_next),
        .retry_next          (retry_next),
        .res                 (res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (step_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg   <= s_axis_tuser[2:0];
            in_proc_reg  <= s_axis_tdata[0];
            in_reply_reg <= s_axis_tdata[1];
        end
    end

    // protocol state advances with each event that moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            retry_reg <= '0;
        end else if (step_fire) begin
            phase_reg <= phase_next;
            retry_reg <= retry_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OutDataWidth - ResWidth){1'b0}}, out_res_reg};

    a_final_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FINALIZED |=> phase_reg == PH_FINALIZED)
        else $error("left finalized phase without reset");

    a_retry_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> retry_reg >= $past(retry_reg))
        else $error("retry count decreased");

    a_unexpected_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && res.unexpected |=>
            phase_reg == $past(phase_reg) && retry_reg == $past(retry_reg))
        else $error("unexpected event changed state");

    a_held_event: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_cmd_reg))
        else $error("buffered event lost while result stalled");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking bench for request_response_ack_retry_fsm: one event per transaction in,
// one result per event out, each checked against an in-bench prediction of the controller.
// Needs rrar_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_top
    import rrar_pkg::*;
();

    localparam int CycleLimit = 200000;
    localparam int PhaseItems = 150;
    localparam int NumPhases  = 7;
    localparam int TailItems  = 50;

    typedef struct {
        phase_t                phase;
        logic [CountWidth-1:0] retries;
    } arq_state_t;

    typedef struct {
        event_t cmd;
        logic   is_proc;
        logic   reply_ok;
    } arq_item_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [InDataWidth-1:0]  s_axis_tdata = '0;
    logic [InUserWidth-1:0]  s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OutDataWidth-1:0] m_axis_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CfgIdxWidth-1:0]  cfg_index = '0;
    logic [CountWidth-1:0]   cfg_data = '0;

    arq_item_t  event_q[$];
    result_t    outcome_q[$];
    arq_state_t fsm_now;
    arq_state_t plan_fsm;
    cfg_t       cfg_now;
    arq_item_t  drv_item;
    bit         client_path;
    bit         calm = 1'b0;
    int         send_gap = 0;
    int         stall_left = 0;
    int         hold_left = 0;
    int         hold_token = 0;
    int         hold_seen = 0;
    int         errors = 0;
    int         cycles = 0;

    request_response_ack_retry_fsm dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Next state and result of the controller for one event.
    function automatic result_t arq_outcome(inout arq_state_t st, input cfg_t cfg,
                                            input arq_item_t it);
        result_t               r;
        event_t                ev;
        logic                  client;
        logic                  take_resp;
        logic                  take_err;
        logic                  take_timeout;
        logic [CountWidth-1:0] limit;
        timer_act_t            restart;
        r = '0;
        ev = it.cmd;
        take_resp = 1'b0;
        take_err = 1'b0;
        take_timeout = 1'b0;
        limit = '0;
        restart = TM_NONE;
        client = (st.phase == PH_REQ_SENT) || (st.phase == PH_ACK_RECV);
        // a processing ERROR stands in for an ACK while a peer answer is awaited
        if (ev == EV_RECV_ERROR && it.is_proc && (client || st.phase == PH_RESP_SENT))
            ev = EV_RECV_ACK;
        case (st.phase)
            PH_IDLE: begin
                if (ev == EV_SEND_REQ) begin
                    st.phase = PH_REQ_SENT;
                    r.transmit_kind = TX_REQUEST;
                    r.timer_action = TM_ACK_WAIT;
                end else if (ev == EV_RECV_REQ) begin
                    st.phase = PH_APP_PROCESS;
                    r.transmit_kind = TX_ACK;
                    r.app_delivery = DLV_MESSAGE;
                end else begin
                    r.unexpected = 1'b1;
                end
            end
            PH_REQ_SENT: begin
                case (ev)
                    EV_RECV_ACK: begin
                        st.phase = PH_ACK_RECV;
                        r.timer_action = TM_RESP_WAIT;
                    end
                    EV_RECV_RESP: take_resp = 1'b1;
                    EV_ACK_TIMEOUT: begin
                        take_timeout = 1'b1;
                        limit = cfg.ack_max;
                        restart = TM_ACK_WAIT;
                    end
                    EV_RECV_ERROR: take_err = 1'b1;
                    default: r.unexpected = 1'b1;
                endcase
            end
            PH_ACK_RECV: begin
                case (ev)
                    EV_RECV_RESP: take_resp = 1'b1;
                    EV_RESP_TIMEOUT: begin
                        take_timeout = 1'b1;
                        limit = cfg.resp_max;
                        restart = TM_RESP_WAIT;
                    end
                    EV_RECV_ACK: ;
                    EV_RECV_ERROR: take_err = 1'b1;
                    default: r.unexpected = 1'b1;
                endcase
            end
            PH_APP_PROCESS: begin
                if (ev == EV_APP_DONE) begin
                    st.phase = PH_RESP_SENT;
                    r.transmit_kind = it.reply_ok ? TX_RESPONSE : TX_ERR_NOTOK;
                    r.timer_action = TM_ACK_WAIT;
                end else if (ev == EV_RECV_REQ) begin
                    r.transmit_kind = cfg.proc_flag ? TX_ERR_PROC : TX_ACK;
                end else begin
                    r.unexpected = 1'b1;
                end
            end
            PH_RESP_SENT: begin
                case (ev)
                    EV_RECV_ACK: begin
                        st.phase = PH_FINALIZED;
                        r.timer_action = TM_CANCEL;
                        r.finalized = 1'b1;
                        r.finish_code = FIN_NORMAL;
                    end
                    EV_RECV_REQ: ;
                    EV_ACK_TIMEOUT: begin
                        take_timeout = 1'b1;
                        limit = cfg.ack_max;
                        restart = TM_ACK_WAIT;
                    end
                    EV_RECV_ERROR: take_err = 1'b1;
                    default: r.unexpected = 1'b1;
                endcase
            end
            default: r.unexpected = 1'b1;
        endcase
        if (take_resp || take_err) begin
            st.phase = PH_FINALIZED;
            r.transmit_kind = TX_ACK;
            r.timer_action = TM_CANCEL;
            r.app_delivery = (take_resp || client) ? DLV_MESSAGE : DLV_NONE;
            r.finalized = 1'b1;
            r.finish_code = take_resp ? FIN_NORMAL : FIN_ERROR;
        end
        if (take_timeout) begin
            if (st.retries != RetrySat)
                st.retries++;
            if (st.retries > limit) begin
                st.phase = PH_FINALIZED;
                r.finalized = 1'b1;
                r.finish_code = FIN_RETRIES;
                r.app_delivery = client ? DLV_FAILURE : DLV_NONE;
            end else begin
                r.transmit_kind = TX_RETRANSMIT;
                r.timer_action = restart;
            end
        end
        r.new_phase = st.phase;
        r.retry_count_out = st.retries;
        return r;
    endfunction

    // Mostly events that keep the operation alive in its current phase, some noise.
    // Outside the closing stretch, anything that would finalize is redrawn.
    function automatic arq_item_t draw_event(arq_state_t st, cfg_t cfg, bit closing);
        arq_item_t  it;
        arq_state_t trial;
        result_t    r;
        int         pick;
        do begin
            pick = $urandom_range(0, 99);
            it.is_proc = 1'($urandom_range(0, 1));
            it.reply_ok = 1'($urandom_range(0, 1));
            it.cmd = event_t'($urandom_range(0, 7));
            if (pick >= 20) begin
                case (st.phase)
                    PH_IDLE: it.cmd = client_path ? EV_SEND_REQ : EV_RECV_REQ;
                    PH_REQ_SENT: begin
                        if (pick < 90) begin
                            it.cmd = EV_ACK_TIMEOUT;
                        end else if (pick < 95) begin
                            it.cmd = EV_RECV_ACK;
                        end else begin
                            it.cmd = EV_RECV_ERROR;
                            it.is_proc = 1'b1;
                        end
                    end
                    PH_ACK_RECV: begin
                        if (pick < 85)
                            it.cmd = EV_RESP_TIMEOUT;
                        else if (pick < 92)
                            it.cmd = EV_RECV_ACK;
                        else
                            it.cmd = EV_RECV_ERROR;
                    end
                    PH_APP_PROCESS: it.cmd = (pick < 92) ? EV_RECV_REQ : EV_APP_DONE;
                    PH_RESP_SENT: it.cmd = (pick < 80) ? EV_ACK_TIMEOUT : EV_RECV_REQ;
                    default: ;
                endcase
            end
            trial = st;
            r = arq_outcome(trial, cfg, it);
        end while (!closing && r.finalized);
        return it;
    endfunction

    function automatic logic [CountWidth-1:0] pick_limit();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return RetrySat;
        if (pick == 6)
            return '0;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void push_event(arq_item_t it);
        event_q.push_back(it);
        void'(arq_outcome(plan_fsm, cfg_now, it));
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [CountWidth-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ACK_MAX:  cfg_now.ack_max = val;
            CFG_RESP_MAX: cfg_now.resp_max = val;
            CFG_PROC:     cfg_now.proc_flag = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [CountWidth-1:0] ack_max, logic [CountWidth-1:0] resp_max,
                             logic proc);
        write_reg(CFG_ACK_MAX, ack_max);
        write_reg(CFG_RESP_MAX, resp_max);
        write_reg(CFG_PROC, {7'($urandom_range(0, 127)), proc});
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (event_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0);
    endtask

    // Event driver: present queued events, with random idle bursts between them.
    always @(posedge aclk) begin
        bit load;
        load = 1'b0;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                outcome_q.push_back(arq_outcome(fsm_now, cfg_now, drv_item));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (event_q.size() > 0) begin
                    if (!calm && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(0, 5);
                    else
                        load = 1'b1;
                end
                if (load) begin
                    drv_item = event_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= drv_item.cmd;
                    s_axis_tdata <= {6'b0, drv_item.reply_ok, drv_item.is_proc};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each transaction, throttle tready.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = result_t'(m_axis_tdata[21:0]);
                if (outcome_q.size() == 0) begin
                    $error("result transaction with no prediction pending: %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("new_phase", want.new_phase, got.new_phase);
                    check_field("transmit_kind", want.transmit_kind, got.transmit_kind);
                    check_field("timer_action", want.timer_action, got.timer_action);
                    check_field("retry_count_out", want.retry_count_out,
                                got.retry_count_out);
                    check_field("app_delivery", want.app_delivery, got.app_delivery);
                    check_field("finalized", want.finalized, got.finalized);
                    check_field("finish_code", want.finish_code, got.finish_code);
                    check_field("unexpected", want.unexpected, got.unexpected);
                    check_field("tdata padding", 0, m_axis_tdata[23:22]);
                end
            end
            if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int n;
        fsm_now = '{PH_IDLE, '0};
        plan_fsm = '{PH_IDLE, '0};
        cfg_now = '{RetryMaxReset, RetryMaxReset, 1'b0};
        client_path = 1'($urandom_range(0, 1));
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // unused register slot: the write must change nothing
        write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        @(negedge aclk);

        // directed: every event refused in idle, then one path with reset limits
        push_event('{EV_RECV_ACK, 1'b0, 1'b0});
        push_event('{EV_RECV_RESP, 1'b1, 1'b1});
        push_event('{EV_RECV_ERROR, 1'b1, 1'b0});
        push_event('{EV_RECV_ERROR, 1'b0, 1'b1});
        push_event('{EV_ACK_TIMEOUT, 1'b0, 1'b0});
        push_event('{EV_RESP_TIMEOUT, 1'b1, 1'b1});
        push_event('{EV_APP_DONE, 1'b0, 1'b1});
        if (client_path) begin
            push_event('{EV_SEND_REQ, 1'b0, 1'b0});
            push_event('{EV_RECV_REQ, 1'b0, 1'b0});
            push_event('{EV_APP_DONE, 1'b1, 1'b1});
            push_event('{EV_RESP_TIMEOUT, 1'b0, 1'b0});
            push_event('{EV_SEND_REQ, 1'b1, 1'b0});
            push_event('{EV_ACK_TIMEOUT, 1'b0, 1'b0});
            push_event('{EV_ACK_TIMEOUT, 1'b0, 1'b1});
            push_event('{EV_RECV_ERROR, 1'b1, 1'b0});
            push_event('{EV_RECV_ACK, 1'b0, 1'b0});
            push_event('{EV_RECV_ERROR, 1'b1, 1'b1});
            push_event('{EV_RESP_TIMEOUT, 1'b0, 1'b0});
            push_event('{EV_ACK_TIMEOUT, 1'b1, 1'b0});
        end else begin
            push_event('{EV_RECV_REQ, 1'b0, 1'b0});
            push_event('{EV_RECV_REQ, 1'b1, 1'b1});
            push_event('{EV_SEND_REQ, 1'b0, 1'b0});
            push_event('{EV_RECV_ACK, 1'b0, 1'b0});
            push_event('{EV_RECV_ERROR, 1'b1, 1'b0});
            push_event('{EV_ACK_TIMEOUT, 1'b0, 1'b0});
            push_event('{EV_APP_DONE, 1'b0, 1'($urandom_range(0, 1))});
            push_event('{EV_RECV_REQ, 1'b1, 1'b0});
            push_event('{EV_APP_DONE, 1'b0, 1'b1});
            push_event('{EV_RESP_TIMEOUT, 1'b0, 1'b0});
            push_event('{EV_ACK_TIMEOUT, 1'b0, 1'b0});
            push_event('{EV_ACK_TIMEOUT, 1'b1, 1'b1});
            push_event('{EV_ACK_TIMEOUT, 1'b0, 1'b0});
        end
        wait_drained();

        // random phases; limits change only while nothing is in flight
        for (int ph = 0; ph < NumPhases; ph++) begin
            if (ph == 0)
                write_all('0, '0, 1'b1);
            else if (ph == 1)
                write_all(RetrySat, RetrySat, 1'b0);
            else
                write_all(pick_limit(), pick_limit(), 1'($urandom_range(0, 1)));
            calm = (ph == 4);
            // long sink hold-off while events keep coming: the input must back up
            if (ph == 2)
                hold_token++;
            for (int i = 0; i < PhaseItems; i++)
                push_event(draw_event(plan_fsm, cfg_now, 1'b0));
            wait_drained();
        end

        // closing: let the operation finish, then show it stays finalized
        calm = 1'b1;
        write_all(($urandom_range(0, 3) == 0) ? RetrySat : 8'($urandom_range(0, 254)),
                  8'($urandom_range(0, 254)), 1'($urandom_range(0, 1)));
        n = 0;
        while (plan_fsm.phase != PH_FINALIZED && n < 400) begin
            push_event(draw_event(plan_fsm, cfg_now, 1'b1));
            n++;
        end
        for (int i = 0; i < TailItems; i++)
            push_event(draw_event(plan_fsm, cfg_now, 1'b1));
        wait_drained();
        repeat (8) @(posedge aclk);

        if (errors == 0 && outcome_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
